// ===== src/qrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared constants, result codes and the solution-kind type.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned COEFF_WIDTH_DEF = 16;
  localparam int unsigned ROOT_WIDTH_DEF  = 32;

  // Fixed-point scaling: coefficients are Q8.8 and roots are Q16.16.
  localparam int unsigned SQRT_SHIFT = 30;
  localparam int unsigned HALF_SHIFT = 15;
  localparam int unsigned LIN_SHIFT  = 16;

  localparam logic [1:0] COUNT_NONE = 2'd0;
  localparam logic [1:0] COUNT_ONE  = 2'd1;
  localparam logic [1:0] COUNT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIN  = 2'd1,
    KIND_ONE  = 2'd2,
    KIND_TWO  = 2'd3
  } kind_e;

endpackage

// ===== src/quadratic_root_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients and reports the
// number of real roots and the roots in signed Q16.16, with saturation.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while in_ready_o is high. Each item
// passes through COEFF_WIDTH + 16 square-root stages (one per root bit),
// COEFF_WIDTH + 17 divider stages (one per numerator bit) and seven further
// stages. The square root and the restoring dividers resolve one bit per stage.
// A skid register behind the output register means in_ready_o falls only
// when two finished items wait; the whole pipeline then holds.
module quadratic_root_solver #(
  parameter int unsigned COEFF_WIDTH = qrs_pkg::COEFF_WIDTH_DEF,
  parameter int unsigned ROOT_WIDTH  = qrs_pkg::ROOT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COEFF_WIDTH-1:0] coef_quad_i,
  input  logic signed [COEFF_WIDTH-1:0] coef_lin_i,
  input  logic signed [COEFF_WIDTH-1:0] coef_const_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    root_count_o,
  output logic signed [ROOT_WIDTH-1:0]  root_plus_o,
  output logic signed [ROOT_WIDTH-1:0]  root_minus_o,
  output logic                          saturated_o
);
  import qrs_pkg::*;

  localparam int unsigned W     = COEFF_WIDTH;
  localparam int unsigned PW    = 2 * W;
  localparam int unsigned DW    = 2 * W + 3;
  localparam int unsigned RADW0 = DW - 1 + SQRT_SHIFT;
  localparam int unsigned RADW  = RADW0 + (RADW0 % 2);
  localparam int unsigned SW    = RADW / 2;
  localparam int unsigned REMW  = SW + 2;
  localparam int unsigned NMW   = ((SW > W + LIN_SHIFT - 1) ? SW : W + LIN_SHIFT - 1) + 1;
  localparam int unsigned NUMW  = NMW + 1;
  localparam int unsigned DRW   = W + 1;
  localparam int unsigned QW    = ((NMW > ROOT_WIDTH) ? NMW : ROOT_WIDTH) + 1;

  typedef struct packed {
    logic [1:0]                   count;
    logic signed [ROOT_WIDTH-1:0] plus;
    logic signed [ROOT_WIDTH-1:0] minus;
    logic                         sat;
  } res_t;

  logic adv;

  // Products.
  logic                 s1_v_q;
  logic signed [PW-1:0] s1_bb_q, s1_ac_q;
  logic signed [W-1:0]  s1_a_q, s1_b_q, s1_c_q;

  // Square-root pipeline.
  logic [SW:0]          sq_v_q;
  logic [REMW-1:0]      sq_rem_q  [SW+1];
  logic [REMW-1:0]      sq_rem_d  [SW+1];
  logic [SW-1:0]        sq_root_q [SW+1];
  logic [SW-1:0]        sq_root_d [SW+1];
  logic [RADW-1:0]      sq_rad_q  [SW+1];
  logic [RADW-1:0]      sq_rad_d  [SW+1];
  kind_e                sq_kind_q [SW+1];
  kind_e                sq_kind_d [SW+1];
  logic signed [W-1:0]  sq_a_q    [SW+1];
  logic signed [W-1:0]  sq_a_d    [SW+1];
  logic signed [W-1:0]  sq_b_q    [SW+1];
  logic signed [W-1:0]  sq_b_d    [SW+1];
  logic signed [W-1:0]  sq_c_q    [SW+1];
  logic signed [W-1:0]  sq_c_d    [SW+1];

  // Numerators.
  logic                   n1_v_q;
  logic signed [NUMW-1:0] n1_np_q, n1_nm_q, n1_np_d, n1_nm_d;
  logic signed [W-1:0]    n1_den_q, n1_den_d;
  kind_e                  n1_kind_q;

  // Divider pipeline, lane 0 for the plus root and lane 1 for the minus root.
  logic [NMW:0]     dv_v_q;
  logic [NMW-1:0]   dv_nq_q   [NMW+1][2];
  logic [NMW-1:0]   dv_nq_d   [NMW+1][2];
  logic [DRW-1:0]   dv_r_q    [NMW+1][2];
  logic [DRW-1:0]   dv_r_d    [NMW+1][2];
  logic [1:0]       dv_neg_q  [NMW+1];
  logic [1:0]       dv_neg_d  [NMW+1];
  logic [W-1:0]     dv_dmag_q [NMW+1];
  logic [W-1:0]     dv_dmag_d [NMW+1];
  kind_e            dv_kind_q [NMW+1];
  kind_e            dv_kind_d [NMW+1];

  // Rounding, saturation and output.
  logic              r1_v_q;
  logic [QW-1:0]     r1_q_q [2];
  logic [QW-1:0]     r1_q_d [2];
  logic [1:0]        r1_neg_q;
  kind_e             r1_kind_q;
  logic              p_v_q;
  res_t              p_q, p_d;
  logic              out_v_q, skid_v_q, out_take;
  res_t              out_q, skid_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      sq_v_q <= '0;
      n1_v_q <= 1'b0;
      dv_v_q <= '0;
      r1_v_q <= 1'b0;
      p_v_q  <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      sq_v_q <= {sq_v_q[SW-1:0], s1_v_q};
      n1_v_q <= sq_v_q[SW];
      dv_v_q <= {dv_v_q[NMW-1:0], n1_v_q};
      r1_v_q <= dv_v_q[NMW];
      p_v_q  <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_bb_q <= coef_lin_i * coef_lin_i;
      s1_ac_q <= coef_quad_i * coef_const_i;
      s1_a_q  <= coef_quad_i;
      s1_b_q  <= coef_lin_i;
      s1_c_q  <= coef_const_i;
    end
  end

  always_comb begin
    logic signed [DW-1:0] disc;
    logic [REMW-1:0]      rem_sh;
    logic [REMW-1:0]      trial;
    logic                 take;
    disc = DW'(s1_bb_q) - (DW'(s1_ac_q) <<< 2);
    if (s1_a_q == '0) begin
      sq_kind_d[0] = (s1_b_q != '0) ? KIND_LIN : KIND_NONE;
    end else if (disc > 0) begin
      sq_kind_d[0] = KIND_TWO;
    end else if (disc == '0) begin
      sq_kind_d[0] = KIND_ONE;
    end else begin
      sq_kind_d[0] = KIND_NONE;
    end
    sq_rad_d[0]  = (sq_kind_d[0] == KIND_TWO) ? (RADW'(disc[DW-2:0]) << SQRT_SHIFT) : '0;
    sq_rem_d[0]  = '0;
    sq_root_d[0] = '0;
    sq_a_d[0]    = s1_a_q;
    sq_b_d[0]    = s1_b_q;
    sq_c_d[0]    = s1_c_q;
    for (int k = 0; k < SW; k++) begin
      rem_sh = {sq_rem_q[k][REMW-3:0], sq_rad_q[k][RADW-1 -: 2]};
      trial  = {sq_root_q[k], 2'b01};
      take   = (rem_sh >= trial);
      sq_rem_d[k+1]  = take ? rem_sh - trial : rem_sh;
      sq_root_d[k+1] = {sq_root_q[k][SW-2:0], take};
      sq_rad_d[k+1]  = sq_rad_q[k] << 2;
      sq_kind_d[k+1] = sq_kind_q[k];
      sq_a_d[k+1]    = sq_a_q[k];
      sq_b_d[k+1]    = sq_b_q[k];
      sq_c_d[k+1]    = sq_c_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
      sq_rad_q  <= sq_rad_d;
      sq_kind_q <= sq_kind_d;
      sq_a_q    <= sq_a_d;
      sq_b_q    <= sq_b_d;
      sq_c_q    <= sq_c_d;
    end
  end

  always_comb begin
    logic signed [NUMW-1:0] nb;
    logic signed [NUMW-1:0] s_x;
    nb  = -(NUMW'(sq_b_q[SW]) <<< HALF_SHIFT);
    s_x = $signed(NUMW'({1'b0, sq_root_q[SW]}));
    case (sq_kind_q[SW])
      KIND_LIN: begin
        n1_np_d  = -(NUMW'(sq_c_q[SW]) <<< LIN_SHIFT);
        n1_nm_d  = '0;
        n1_den_d = sq_b_q[SW];
      end
      KIND_TWO: begin
        n1_np_d  = nb + s_x;
        n1_nm_d  = nb - s_x;
        n1_den_d = sq_a_q[SW];
      end
      default: begin
        n1_np_d  = nb;
        n1_nm_d  = nb;
        n1_den_d = sq_a_q[SW];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_np_q   <= n1_np_d;
      n1_nm_q   <= n1_nm_d;
      n1_den_q  <= n1_den_d;
      n1_kind_q <= sq_kind_q[SW];
    end
  end

  always_comb begin
    logic signed [NUMW-1:0] num;
    logic signed [NUMW-1:0] mag;
    logic signed [W-1:0]    dm;
    logic [DRW-1:0]         r_sh;
    logic                   take;
    dm = n1_den_q[W-1] ? -n1_den_q : n1_den_q;
    dv_dmag_d[0] = dm;
    dv_kind_d[0] = n1_kind_q;
    for (int j = 0; j < 2; j++) begin
      num = (j == 0) ? n1_np_q : n1_nm_q;
      mag = num[NUMW-1] ? -num : num;
      dv_neg_d[0][j] = num[NUMW-1] ^ n1_den_q[W-1];
      dv_nq_d[0][j]  = mag[NMW-1:0];
      dv_r_d[0][j]   = '0;
    end
    for (int k = 0; k < NMW; k++) begin
      dv_dmag_d[k+1] = dv_dmag_q[k];
      dv_kind_d[k+1] = dv_kind_q[k];
      dv_neg_d[k+1]  = dv_neg_q[k];
      for (int j = 0; j < 2; j++) begin
        r_sh = {dv_r_q[k][j][DRW-2:0], dv_nq_q[k][j][NMW-1]};
        take = (r_sh >= {1'b0, dv_dmag_q[k]});
        dv_r_d[k+1][j]  = take ? r_sh - {1'b0, dv_dmag_q[k]} : r_sh;
        dv_nq_d[k+1][j] = {dv_nq_q[k][j][NMW-2:0], take};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_nq_q   <= dv_nq_d;
      dv_r_q    <= dv_r_d;
      dv_neg_q  <= dv_neg_d;
      dv_dmag_q <= dv_dmag_d;
      dv_kind_q <= dv_kind_d;
    end
  end

  always_comb begin
    logic inc;
    for (int j = 0; j < 2; j++) begin
      inc = ({dv_r_q[NMW][j], 1'b0} >= {2'b00, dv_dmag_q[NMW]});
      r1_q_d[j] = QW'(dv_nq_q[NMW][j]) + QW'(inc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1_q_q    <= r1_q_d;
      r1_neg_q  <= dv_neg_q[NMW];
      r1_kind_q <= dv_kind_q[NMW];
    end
  end

  always_comb begin
    logic [QW-1:0]         lim;
    logic [QW-1:0]         qs;
    logic [QW-1:0]         val;
    logic [ROOT_WIDTH-1:0] root [2];
    logic [1:0]            sat;
    for (int j = 0; j < 2; j++) begin
      lim     = (QW'(1) << (ROOT_WIDTH - 1)) - (r1_neg_q[j] ? QW'(0) : QW'(1));
      sat[j]  = (r1_q_q[j] > lim);
      qs      = sat[j] ? lim : r1_q_q[j];
      val     = r1_neg_q[j] ? -qs : qs;
      root[j] = val[ROOT_WIDTH-1:0];
    end
    p_d = '0;
    case (r1_kind_q)
      KIND_TWO: begin
        p_d.count = COUNT_TWO;
        p_d.plus  = root[0];
        p_d.minus = root[1];
        p_d.sat   = sat[0] | sat[1];
      end
      KIND_LIN, KIND_ONE: begin
        p_d.count = COUNT_ONE;
        p_d.plus  = root[0];
        p_d.sat   = sat[0];
      end
      default: begin
        p_d.count = COUNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q <= p_d;
    end
  end

  assign out_take = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      out_v_q  <= skid_v_q | p_v_q;
      skid_v_q <= 1'b0;
    end else if (adv && p_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_v_q ? skid_q : p_q;
    end else if (adv && p_v_q) begin
      skid_q <= p_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign root_count_o = out_q.count;
  assign root_plus_o  = out_q.plus;
  assign root_minus_o = out_q.minus;
  assign saturated_o  = out_q.sat;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("Skid register holds an item while the output register is empty.");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_take |=> skid_v_q && $stable(skid_q))
    else $error("Skid item lost while the output was stalled.");

  a_no_root_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.count == COUNT_NONE |->
      out_q.plus == '0 && out_q.minus == '0 && !out_q.sat)
    else $error("Result without roots carries root data.");

  a_minus_only_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.count != COUNT_TWO |-> out_q.minus == '0)
    else $error("Minus root reported without two roots.");

  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.count == COUNT_NONE || out_q.count == COUNT_ONE ||
      out_q.count == COUNT_TWO)
    else $error("Root count out of range.");
`endif

endmodule
